// File: hw/rtl/blrp_pkg.sv
package blrp_pkg;

  // Width of the item fields and of the configuration registers
  localparam int unsigned FieldW = 16;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic REG_REGION_WIDTH  = 1'b0;
  localparam logic REG_REGION_HEIGHT = 1'b1;

  localparam logic [FieldW-1:0] RegionReset = 16'hFFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;     // latch the item, restart the candidate scan
    logic issue;     // read one candidate pair and advance the counters
    logic load_out;  // move the best corner into the output register
    logic commit;    // store the placed rectangle
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;        // store holds MAX_ITEMS rectangles
    logic last_issue;  // the pair being issued is the final one
    logic found;       // a fitting corner has been found
  } sts_t;

endpackage

// File: hw/rtl/bottom_left_rectangle_placer.sv
// Bottom-left rectangle placer.
// Input channel (in_valid_i/in_ready_o): one item = rect_width_i, rect_height_i.
// Output channel (out_valid_o/out_ready_i): one item per input = placed_o,
// pos_x_o, pos_y_o (lower-left corner, zero when not placed).
// Region size is set over the APB port: reg 0 region width (0x0), reg 1
// region height (0x4); write only while the block is idle.
// Scan: with N rectangles stored, the scan visits (N+1)^2 candidate
// corners, one per cycle. Each cycle reads one right edge and one top
// edge from two RAMs; the overlap test runs across all slots in parallel.
// Once the store is full an item skips the scan and is finished without
// being placed.
// One item is worked on at a time; a new item is taken while the previous
// result still waits in the output register.
// If the receiver stalls, the finished result waits in the datapath until
// the output register frees up, and no new item is accepted meanwhile.
// Reset empties the store and sets both region registers to 65535.
module bottom_left_rectangle_placer #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] rect_width_i,
  input  logic [15:0] rect_height_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        placed_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o
);

  localparam int unsigned FW = blrp_pkg::FieldW;

  logic [FW-1:0]  region_w_q, region_h_q;
  logic           wr_en;
  blrp_pkg::cmd_t cmd;
  blrp_pkg::sts_t sts;

  // APB: zero wait states, byte offset bits ignored
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_w_q <= blrp_pkg::RegionReset;
      region_h_q <= blrp_pkg::RegionReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        blrp_pkg::REG_REGION_WIDTH:  region_w_q <= pwdata[FW-1:0];
        blrp_pkg::REG_REGION_HEIGHT: region_h_q <= pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      blrp_pkg::REG_REGION_WIDTH:  prdata = 32'(region_w_q);
      blrp_pkg::REG_REGION_HEIGHT: prdata = 32'(region_h_q);
      default:                     prdata = '0;
    endcase
  end

  blrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  blrp_datapath #(
    .MaxItems (MAX_ITEMS),
    .CoordBits(COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .region_width_i (region_w_q),
    .region_height_i(region_h_q),
    .placed_o       (placed_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o)
  );

endmodule

// File: hw/rtl/blrp_ram.sv
module blrp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/blrp_datapath.sv
module blrp_datapath #(
  parameter int unsigned MaxItems  = 64,
  parameter int unsigned CoordBits = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  blrp_pkg::cmd_t              cmd_i,
  output blrp_pkg::sts_t              sts_o,
  input  logic [blrp_pkg::FieldW-1:0] rect_width_i,
  input  logic [blrp_pkg::FieldW-1:0] rect_height_i,
  input  logic [blrp_pkg::FieldW-1:0] region_width_i,
  input  logic [blrp_pkg::FieldW-1:0] region_height_i,
  output logic                        placed_o,
  output logic [blrp_pkg::FieldW-1:0] pos_x_o,
  output logic [blrp_pkg::FieldW-1:0] pos_y_o
);

  localparam int unsigned AW   = $clog2(MaxItems);
  localparam int unsigned CNTW = $clog2(MaxItems + 1);
  // candidate and far-edge width: wide enough for coord + field without wrap
  localparam int unsigned SW   =
    ((CoordBits > blrp_pkg::FieldW) ? CoordBits : blrp_pkg::FieldW) + 1;
  localparam int unsigned FW   = blrp_pkg::FieldW;

  // item
  logic [FW-1:0] w_q, h_q;

  // stored rectangles, compared in parallel
  logic [MaxItems-1:0]  vld_q;
  logic [MaxItems-1:0]  nz_q;
  logic [CoordBits-1:0] left_q   [MaxItems];
  logic [CoordBits-1:0] bottom_q [MaxItems];
  logic [CoordBits-1:0] right_q  [MaxItems];
  logic [CoordBits-1:0] top_q    [MaxItems];
  logic [CNTW-1:0]      cnt_q;

  // scan counters: index 0 is the origin, k+1 is slot k
  logic [CNTW-1:0] i_q, j_q;
  logic [CNTW-1:0] im1, jm1;
  logic [AW-1:0]   raddr_x, raddr_y;

  // pipeline
  logic          va_q, ia0_q, ja0_q;
  logic          vb_q;
  logic [SW-1:0] cx_q, cy_q, ex_q, ey_q;
  logic [SW-1:0] cx_a, cy_a;
  logic [CoordBits-1:0] rx_rdata, ry_rdata;

  // best corner
  logic          found_q;
  logic [SW-1:0] bx_q, by_q;

  logic                 last_issue;
  logic [MaxItems-1:0]  hit;
  logic                 any_hit, fits, better, take;
  logic [SW-1:0]        new_r, new_t;
  logic [CoordBits-1:0] new_l, new_b, new_rc, new_tc;

  assign im1        = i_q - 1'b1;
  assign jm1        = j_q - 1'b1;
  assign raddr_x    = (i_q == '0) ? '0 : im1[AW-1:0];
  assign raddr_y    = (j_q == '0) ? '0 : jm1[AW-1:0];
  assign last_issue = (i_q == cnt_q) && (j_q == cnt_q);

  assign new_r  = bx_q + SW'(w_q);
  assign new_t  = by_q + SW'(h_q);
  assign new_l  = bx_q[CoordBits-1:0];
  assign new_b  = by_q[CoordBits-1:0];
  assign new_rc = new_r[CoordBits-1:0];
  assign new_tc = new_t[CoordBits-1:0];

  blrp_ram #(.Width(CoordBits), .Depth(MaxItems)) u_ram_x (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(new_rc),
    .raddr_i(raddr_x),
    .rdata_o(rx_rdata)
  );

  blrp_ram #(.Width(CoordBits), .Depth(MaxItems)) u_ram_y (
    .clk_i  (clk_i),
    .we_i   (cmd_i.commit),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(new_tc),
    .raddr_i(raddr_y),
    .rdata_o(ry_rdata)
  );

  assign cx_a = ia0_q ? '0 : SW'(rx_rdata);
  assign cy_a = ja0_q ? '0 : SW'(ry_rdata);

  // overlap of the candidate against every stored rectangle
  always_comb begin
    for (int k = 0; k < MaxItems; k++) begin
      hit[k] = vld_q[k] && nz_q[k]
            && (cx_q < SW'(right_q[k])) && (SW'(left_q[k]) < ex_q)
            && (cy_q < SW'(top_q[k]))   && (SW'(bottom_q[k]) < ey_q);
    end
  end

  assign any_hit = (|w_q) && (|h_q) && (|hit);
  assign fits    = (ex_q <= SW'(region_width_i)) && (ey_q <= SW'(region_height_i));
  assign better  = !found_q || (cx_q < bx_q) || ((cx_q == bx_q) && (cy_q < by_q));
  assign take    = vb_q && fits && better && !any_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      vld_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      va_q <= cmd_i.issue;
      vb_q <= va_q;
      if (cmd_i.start) begin
        i_q     <= '0;
        j_q     <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          if (j_q == cnt_q) begin
            j_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        vld_q[cnt_q[AW-1:0]] <= 1'b1;
        cnt_q                <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q  <= rect_width_i;
      h_q  <= rect_height_i;
      bx_q <= '0;
      by_q <= '0;
    end else if (take) begin
      bx_q <= cx_q;
      by_q <= cy_q;
    end
    ia0_q <= (i_q == '0);
    ja0_q <= (j_q == '0);
    cx_q  <= cx_a;
    cy_q  <= cy_a;
    ex_q  <= cx_a + SW'(w_q);
    ey_q  <= cy_a + SW'(h_q);
    if (cmd_i.commit) begin
      left_q[cnt_q[AW-1:0]]   <= new_l;
      bottom_q[cnt_q[AW-1:0]] <= new_b;
      right_q[cnt_q[AW-1:0]]  <= new_rc;
      top_q[cnt_q[AW-1:0]]    <= new_tc;
      nz_q[cnt_q[AW-1:0]]     <= (new_l < new_rc) && (new_b < new_tc);
    end
    if (cmd_i.load_out) begin
      placed_o <= found_q;
      pos_x_o  <= found_q ? bx_q[FW-1:0] : '0;
      pos_y_o  <= found_q ? by_q[FW-1:0] : '0;
    end
  end

  assign sts_o.full       = (cnt_q == CNTW'(MaxItems));
  assign sts_o.last_issue = last_issue;
  assign sts_o.found      = found_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MaxItems))
    else $error("store count beyond capacity");

  a_commit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> found_q && !sts_o.full)
    else $error("commit without a found corner");

  a_commit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("count not advanced by commit");

  a_commit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (new_r <= SW'(region_width_i)) && (new_t <= SW'(region_height_i)))
    else $error("placed rectangle leaves the region");
`endif

endmodule

// File: hw/rtl/blrp_ctrl.sv
module blrp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output blrp_pkg::cmd_t cmd_o,
  input  blrp_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.full ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.commit   = sts_i.found;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
